// ----- hw/rtl/tseq_pkg.sv -----
package tseq_pkg;

    // Operation codes carried in the input tuser bit.
    localparam logic OP_ADD   = 1'b0;
    localparam logic OP_CHECK = 1'b1;

    // Shortest command frame, in bytes, that an add accepts.
    localparam logic [7:0] MIN_FRAME_LEN = 8'd11;

    // Payload widths of the two channels.
    localparam int IN_DATA_W  = 56;
    localparam int OUT_DATA_W = 8;

    // Calendar time stamp. The year sits in the most significant bits, so
    // an unsigned compare of the packed word orders stamps field by field.
    typedef struct packed {
        logic [15:0] year;
        logic [3:0]  month;
        logic [4:0]  day;
        logic [4:0]  hour;
        logic [5:0]  minute;
        logic [5:0]  second;
    } stamp_t;

    // One stored switch event.
    typedef struct packed {
        stamp_t stamp;
        logic   turn_on;
    } entry_t;

    // Sequencer states.
    typedef enum logic [1:0] {
        ST_IDLE,
        ST_WALK,
        ST_DONE
    } state_t;

endpackage

// ----- hw/rtl/tseq_store.sv -----
module tseq_store
    import tseq_pkg::*;
#(
    parameter int DEPTH = 10,
    parameter int IDX_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
)
(
    input  logic             clk,
    input  logic             wr_en,
    input  logic [IDX_W-1:0] wr_addr,
    input  entry_t           wr_data,
    input  logic             rd_en,
    input  logic [IDX_W-1:0] rd_addr,
    output entry_t           rd_data
);

    entry_t mem [DEPTH];
    entry_t rd_data_reg;

    // Single write port.
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
    end

    // Single read port with registered data.
    always_ff @(posedge clk)
    begin
        if (rd_en)
        begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

// ----- hw/rtl/tseq_cmp.sv -----
module tseq_cmp
    import tseq_pkg::*;
(
    input  stamp_t a,
    input  stamp_t b,
    output logic   earlier
);

    // Strictly-earlier test on the packed stamp, one 42-bit compare.
    assign earlier = (a < b);

endmodule

// ----- hw/rtl/timed_switch_event_queue.sv -----
// Channel  Direction  Handshake            Payload
// s_*      in         s_tvalid / s_tready  item: op in tuser, event or current time in tdata
// m_*      out        m_tvalid / m_tready  item: status, drive and pending count in tdata
//
// An add item, or a check of an empty queue, skips the walk and goes from idle straight to the done state.
// A check item walks the stored entries through one memory read port, one entry
// per cycle, and then goes to the done state.
// Reset clears the pointers and the entry count; stored entries need no clearing.
// The input is taken whenever the sequencer is idle, even while a result waits;
// a finished item is held until the output register is free.
module timed_switch_event_queue
    import tseq_pkg::*;
#(
    parameter int QUEUE_DEPTH = 10
)
(
    input  logic                  clk,
    input  logic                  rst_n,
    // s_tdata, from bit 0: frame_length[7:0], year[23:8], month[27:24], day[32:28],
    // hour[37:33], minute[43:38], second[49:44], turn_on[50], zero fill[55:51]
    input  logic [IN_DATA_W-1:0]  s_tdata,
    // s_tuser: op[0]
    input  logic                  s_tuser,
    input  logic                  s_tvalid,
    output logic                  s_tready,
    // m_tdata, from bit 0: status[0], drive_valid[1], drive_on[2],
    // pending_count[6:3], zero fill[7]
    output logic [OUT_DATA_W-1:0] m_tdata,
    output logic                  m_tvalid,
    input  logic                  m_tready
);

    localparam int IDX_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

    state_t state_reg, state_next;

    logic [IDX_W-1:0] head_reg, head_next;
    logic [IDX_W-1:0] tail_reg, tail_next;
    logic [IDX_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [IDX_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [CNT_W-1:0] count_reg, count_next;
    logic [CNT_W-1:0] iss_reg, iss_next;
    logic [CNT_W-1:0] kept_reg, kept_next;
    logic             rd_pend_reg, rd_pend_next;
    logic             fired_reg, fired_next;
    logic             don_reg, don_next;
    logic             status_reg, status_next;
    stamp_t           now_reg, now_next;
    logic             m_tvalid_reg, m_tvalid_next;
    logic [OUT_DATA_W-1:0] m_tdata_reg, m_tdata_next;

    entry_t           in_entry;
    logic             in_op;
    logic [7:0]       in_frame_len;
    logic             s_accept;
    logic             add_ok;
    logic             walk_end;
    logic             res_load;

    logic             mem_wr_en;
    logic [IDX_W-1:0] mem_wr_addr;
    entry_t           mem_wr_data;
    logic             mem_rd_en;
    entry_t           mem_rd_data;
    logic             earlier;

    // Circular index step.
    function automatic logic [IDX_W-1:0] inc_idx(input logic [IDX_W-1:0] idx);
        logic [IDX_W-1:0] nxt;
        if (idx == IDX_W'(QUEUE_DEPTH - 1))
        begin
            nxt = '0;
        end
        else
        begin
            nxt = idx + 1'b1;
        end
        return nxt;
    endfunction

    // Unpack the input item.
    assign in_op                 = s_tuser;
    assign in_frame_len          = s_tdata[7:0];
    assign in_entry.stamp.year   = s_tdata[23:8];
    assign in_entry.stamp.month  = s_tdata[27:24];
    assign in_entry.stamp.day    = s_tdata[32:28];
    assign in_entry.stamp.hour   = s_tdata[37:33];
    assign in_entry.stamp.minute = s_tdata[43:38];
    assign in_entry.stamp.second = s_tdata[49:44];
    assign in_entry.turn_on      = s_tdata[50];

    assign s_accept = s_tvalid && s_tready;
    assign add_ok   = (in_frame_len >= MIN_FRAME_LEN);
    assign walk_end = (iss_reg == count_reg) && !rd_pend_reg;

    // Event memory and the time comparator.
    tseq_store #(
        .DEPTH (QUEUE_DEPTH)
    ) u_store (
        .clk     (clk),
        .wr_en   (mem_wr_en),
        .wr_addr (mem_wr_addr),
        .wr_data (mem_wr_data),
        .rd_en   (mem_rd_en),
        .rd_addr (rd_ptr_reg),
        .rd_data (mem_rd_data)
    );

    tseq_cmp u_cmp (
        .a       (mem_rd_data.stamp),
        .b       (now_reg),
        .earlier (earlier)
    );

    // Next state.
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (s_accept)
                begin
                    if ((in_op == OP_CHECK) && (count_reg != '0))
                    begin
                        state_next = ST_WALK;
                    end
                    else
                    begin
                        state_next = ST_DONE;
                    end
                end
            end
            ST_WALK:
            begin
                if (walk_end)
                begin
                    state_next = ST_DONE;
                end
            end
            ST_DONE:
            begin
                if (!m_tvalid_reg || m_tready)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // Sequencer strobes and memory port controls.
    always_comb
    begin
        s_tready    = 1'b0;
        mem_rd_en   = 1'b0;
        mem_wr_en   = 1'b0;
        mem_wr_addr = tail_reg;
        mem_wr_data = in_entry;
        res_load    = 1'b0;
        unique case (state_reg)
            ST_IDLE:
            begin
                s_tready = 1'b1;
                if (s_accept && (in_op == OP_ADD) && add_ok)
                begin
                    mem_wr_en = 1'b1;
                end
            end
            ST_WALK:
            begin
                mem_rd_en = (iss_reg != count_reg);
                if (rd_pend_reg && !earlier)
                begin
                    mem_wr_en   = 1'b1;
                    mem_wr_addr = wr_ptr_reg;
                    mem_wr_data = mem_rd_data;
                end
            end
            ST_DONE:
            begin
                res_load = !m_tvalid_reg || m_tready;
            end
            default:
            begin
                s_tready = 1'b0;
            end
        endcase
    end

    // Datapath and queue bookkeeping.
    always_comb
    begin
        head_next     = head_reg;
        tail_next     = tail_reg;
        rd_ptr_next   = rd_ptr_reg;
        wr_ptr_next   = wr_ptr_reg;
        count_next    = count_reg;
        iss_next      = iss_reg;
        kept_next     = kept_reg;
        rd_pend_next  = 1'b0;
        fired_next    = fired_reg;
        don_next      = don_reg;
        status_next   = status_reg;
        now_next      = now_reg;
        m_tdata_next  = m_tdata_reg;
        m_tvalid_next = m_tvalid_reg;

        // A new item clears the result and sets up the operation.
        if (s_accept)
        begin
            status_next = 1'b0;
            fired_next  = 1'b0;
            don_next    = 1'b0;
            if (in_op == OP_ADD)
            begin
                if (!add_ok)
                begin
                    status_next = 1'b1;
                end
                else
                begin
                    // A full queue loses its oldest entry to the new one.
                    tail_next = inc_idx(tail_reg);
                    if (count_reg == CNT_W'(QUEUE_DEPTH))
                    begin
                        head_next = inc_idx(head_reg);
                    end
                    else
                    begin
                        count_next = count_reg + 1'b1;
                    end
                end
            end
            else
            begin
                rd_ptr_next = head_reg;
                wr_ptr_next = head_reg;
                iss_next    = '0;
                kept_next   = '0;
                now_next    = in_entry.stamp;
            end
        end

        // Walk: survivors are packed down behind the read pointer.
        if (state_reg == ST_WALK)
        begin
            rd_pend_next = mem_rd_en;
            if (mem_rd_en)
            begin
                rd_ptr_next = inc_idx(rd_ptr_reg);
                iss_next    = iss_reg + 1'b1;
            end
            if (rd_pend_reg)
            begin
                if (earlier)
                begin
                    fired_next = 1'b1;
                    don_next   = mem_rd_data.turn_on;
                end
                else
                begin
                    wr_ptr_next = inc_idx(wr_ptr_reg);
                    kept_next   = kept_reg + 1'b1;
                end
            end
            if (walk_end)
            begin
                tail_next  = wr_ptr_reg;
                count_next = kept_reg;
            end
        end

        // Output register.
        if (res_load)
        begin
            m_tvalid_next = 1'b1;
            m_tdata_next  = {1'b0, 4'(count_reg), don_reg, fired_reg, status_reg};
        end
        else if (m_tready)
        begin
            m_tvalid_next = 1'b0;
        end
    end

    // Control registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= ST_IDLE;
            head_reg     <= '0;
            tail_reg     <= '0;
            rd_ptr_reg   <= '0;
            wr_ptr_reg   <= '0;
            count_reg    <= '0;
            iss_reg      <= '0;
            kept_reg     <= '0;
            rd_pend_reg  <= 1'b0;
            fired_reg    <= 1'b0;
            don_reg      <= 1'b0;
            m_tvalid_reg <= 1'b0;
        end
        else
        begin
            state_reg    <= state_next;
            head_reg     <= head_next;
            tail_reg     <= tail_next;
            rd_ptr_reg   <= rd_ptr_next;
            wr_ptr_reg   <= wr_ptr_next;
            count_reg    <= count_next;
            iss_reg      <= iss_next;
            kept_reg     <= kept_next;
            rd_pend_reg  <= rd_pend_next;
            fired_reg    <= fired_next;
            don_reg      <= don_next;
            m_tvalid_reg <= m_tvalid_next;
        end
    end

    // Payload registers.
    always_ff @(posedge clk)
    begin
        status_reg  <= status_next;
        now_reg     <= now_next;
        m_tdata_reg <= m_tdata_next;
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;

    // The entry count never exceeds the queue depth.
    assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CNT_W'(QUEUE_DEPTH))
        else $error("entry count beyond queue depth");

    // During a walk no more entries are kept than have been read.
    assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_WALK) |-> (kept_reg <= iss_reg))
        else $error("kept entries exceed entries read");

    // A rejected add never reports a fired event.
    assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid |-> !(m_tdata[0] && m_tdata[1]))
        else $error("rejected add reports a drive");

    // An accepted item holds off the input for at least the next cycle.
    assert property (@(posedge clk) disable iff (!rst_n)
        s_accept |=> !s_tready)
        else $error("input taken while an item is in progress");

endmodule

// ----- tb/tb_top.sv -----
module tb_top;
    timeunit 1ns;
    timeprecision 1ps;

    import tseq_pkg::*;

    // One expected result, fields as they leave the block.
    typedef struct packed {
        logic       status;
        logic       drive_valid;
        logic       drive_on;
        logic [3:0] pending_count;
    } outcome_t;

    localparam int SCHED_DEPTH = 10;
    localparam int RANDOM_ITEMS = 1130;

    // Keeps its own copy of the event queue and the results still owed by the block.
    class switch_queue_scoreboard;
        entry_t   stored[$];
        outcome_t awaited[$];
        int       errors;

        function new();
            errors = 0;
        endfunction

        // True when a lies strictly before b, field by field from the year down.
        function bit earlier(stamp_t a, stamp_t b);
            if (a.year != b.year) return a.year < b.year;
            if (a.month != b.month) return a.month < b.month;
            if (a.day != b.day) return a.day < b.day;
            if (a.hour != b.hour) return a.hour < b.hour;
            if (a.minute != b.minute) return a.minute < b.minute;
            return a.second < b.second;
        endfunction

        // Applies an accepted input item to the queue and records the result it owes.
        function void note_item(logic op, logic [IN_DATA_W-1:0] data);
            entry_t   ev;
            outcome_t res;
            entry_t   survivors[$];
            ev.stamp.year   = data[23:8];
            ev.stamp.month  = data[27:24];
            ev.stamp.day    = data[32:28];
            ev.stamp.hour   = data[37:33];
            ev.stamp.minute = data[43:38];
            ev.stamp.second = data[49:44];
            ev.turn_on      = data[50];
            res = '0;
            if (op == OP_ADD) begin
                if (data[7:0] < MIN_FRAME_LEN) begin
                    res.status = 1'b1;
                end
                else begin
                    // A full queue loses its oldest event first.
                    if (stored.size() == SCHED_DEPTH)
                        void'(stored.pop_front());
                    stored.push_back(ev);
                end
            end
            else begin
                foreach (stored[i]) begin
                    if (earlier(stored[i].stamp, ev.stamp)) begin
                        res.drive_valid = 1'b1;
                        res.drive_on    = stored[i].turn_on;
                    end
                    else begin
                        survivors.push_back(stored[i]);
                    end
                end
                stored = survivors;
            end
            res.pending_count = 4'(stored.size());
            awaited.push_back(res);
        endfunction

        // Compares an accepted result with the oldest one still owed.
        function void check_result(logic [OUT_DATA_W-1:0] data);
            outcome_t want;
            if (awaited.size() == 0) begin
                $error("result %h arrived with nothing outstanding", data);
                errors++;
                return;
            end
            want = awaited.pop_front();
            if (data[0] !== want.status) begin
                $error("status: expected %0d, actual %0d", want.status, data[0]);
                errors++;
            end
            if (data[1] !== want.drive_valid) begin
                $error("drive_valid: expected %0d, actual %0d", want.drive_valid, data[1]);
                errors++;
            end
            if (data[2] !== want.drive_on) begin
                $error("drive_on: expected %0d, actual %0d", want.drive_on, data[2]);
                errors++;
            end
            if (data[6:3] !== want.pending_count) begin
                $error("pending_count: expected %0d, actual %0d",
                       want.pending_count, data[6:3]);
                errors++;
            end
        endfunction
    endclass

    logic                  clk = 1'b0;
    logic                  rst_n;
    logic [IN_DATA_W-1:0]  s_tdata;
    logic                  s_tuser;
    logic                  s_tvalid;
    logic                  s_tready;
    logic [OUT_DATA_W-1:0] m_tdata;
    logic                  m_tvalid;
    logic                  m_tready;

    switch_queue_scoreboard sb = new();
    int results_seen = 0;

    timed_switch_event_queue #(.QUEUE_DEPTH(SCHED_DEPTH)) dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .m_tdata  (m_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    function automatic stamp_t make_stamp(int y, int mo, int d, int h, int mi, int s);
        stamp_t st;
        st.year   = 16'(y);
        st.month  = 4'(mo);
        st.day    = 5'(d);
        st.hour   = 5'(h);
        st.minute = 6'(mi);
        st.second = 6'(s);
        return st;
    endfunction

    // Stamps from a narrow window, so that ties and near misses are common.
    function automatic stamp_t near_stamp();
        return make_stamp($urandom_range(2024, 2025), $urandom_range(1, 2),
                          $urandom_range(1, 2), $urandom_range(0, 1),
                          $urandom_range(0, 1), $urandom_range(0, 2));
    endfunction

    // Any raw field value, out of calendar range included.
    function automatic stamp_t wild_stamp();
        return make_stamp($urandom_range(0, 65535), $urandom_range(0, 15),
                          $urandom_range(0, 31), $urandom_range(0, 31),
                          $urandom_range(0, 63), $urandom_range(0, 63));
    endfunction

    function automatic logic [IN_DATA_W-1:0] pack_item(logic [7:0] frame, stamp_t st,
                                                       logic on);
        return {5'b0, on, st.second, st.minute, st.hour, st.day, st.month, st.year, frame};
    endfunction

    // Mostly short gaps, now and then a long one.
    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 40) return 0;
        if (r < 90) return $urandom_range(1, 3);
        return $urandom_range(8, 40);
    endfunction

    // Offers one item after a gap of idle cycles and waits until it is taken.
    task automatic send_item(logic op, logic [IN_DATA_W-1:0] data, int gap);
        if (gap > 0)
        begin
            @(negedge clk);
            s_tvalid <= 1'b0;
            repeat (gap - 1) @(negedge clk);
        end
        @(negedge clk);
        s_tvalid <= 1'b1;
        s_tuser  <= op;
        s_tdata  <= data;
        do @(posedge clk); while (s_tready !== 1'b1);
        sb.note_item(op, data);
    endtask

    task automatic send_add(logic [7:0] frame, stamp_t st, logic on);
        send_item(OP_ADD, pack_item(frame, st, on), pick_gap());
    endtask

    task automatic send_check(logic [7:0] frame, stamp_t st, logic on);
        send_item(OP_CHECK, pack_item(frame, st, on), pick_gap());
    endtask

    // Result monitor.
    always @(posedge clk)
    begin
        if (rst_n && m_tvalid && m_tready)
        begin
            sb.check_result(m_tdata);
            results_seen++;
        end
    end

    // Receiver: random stalls, calm stretches, and one long hold-off.
    initial
    begin
        int  stall_left;
        int  hold_left;
        int  stall_pct;
        int  cycle;
        bit  hold_done;
        stall_left = 0;
        hold_left  = 0;
        stall_pct  = 25;
        cycle      = 0;
        hold_done  = 1'b0;
        m_tready   = 1'b0;
        forever
        begin
            @(negedge clk);
            cycle++;
            if (cycle % 256 == 0)
                stall_pct = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(10, 50);
            if (!hold_done && results_seen >= 200)
            begin
                hold_left = 400;
                hold_done = 1'b1;
            end
            if (hold_left > 0)
            begin
                m_tready <= 1'b0;
                hold_left--;
            end
            else if (stall_left > 0)
            begin
                m_tready <= 1'b0;
                stall_left--;
            end
            else
            begin
                m_tready <= 1'b1;
                if ($urandom_range(0, 99) < stall_pct)
                    stall_left = pick_gap();
            end
        end
    end

    // Stimulus and verdict.
    initial
    begin
        int     n;
        int     check_pct;
        bit     burst;
        logic   op;
        logic [7:0] frame;
        stamp_t st;
        rst_n    = 1'b0;
        s_tvalid = 1'b0;
        s_tuser  = OP_ADD;
        s_tdata  = '0;
        check_pct = 30;
        burst     = 1'b0;
        repeat (6) @(negedge clk);
        rst_n <= 1'b1;

        // Directed: empty check, short frames, ties, extremes, overflow, leap second.
        send_check(8'd0, make_stamp(0, 0, 0, 0, 0, 0), 1'b1);
        send_add(8'd10, make_stamp(2024, 6, 15, 12, 30, 30), 1'b1);
        send_add(8'd0, make_stamp(2024, 6, 15, 12, 30, 30), 1'b1);
        send_add(MIN_FRAME_LEN, make_stamp(2024, 6, 15, 12, 30, 30), 1'b1);
        send_check(8'd255, make_stamp(2024, 6, 15, 12, 30, 30), 1'b0);
        send_check(8'd3, make_stamp(2024, 6, 15, 12, 30, 31), 1'b0);
        send_add(8'd255, make_stamp(65535, 15, 31, 31, 63, 63), 1'b1);
        send_add(8'd11, make_stamp(0, 0, 0, 0, 0, 0), 1'b0);
        for (n = 0; n < 9; n++)
            send_add(8'(12 + n), make_stamp(2024, 1, n + 1, n, n * 7, n * 6), n[0]);
        send_add(8'd200, make_stamp(2024, 12, 31, 23, 59, 60), 1'b1);
        send_check(8'd0, make_stamp(2024, 1, 5, 0, 0, 0), 1'b0);
        send_check(8'd0, make_stamp(65535, 15, 31, 31, 63, 63), 1'b1);

        // Random: phases of differing add/check mix and pacing.
        for (n = 0; n < RANDOM_ITEMS; n++)
        begin
            if (n % 100 == 0)
            begin
                burst = ($urandom_range(0, 3) == 0);
                case ($urandom_range(0, 2))
                    0:       check_pct = 10;
                    1:       check_pct = 30;
                    default: check_pct = 60;
                endcase
            end
            op    = ($urandom_range(0, 99) < check_pct) ? OP_CHECK : OP_ADD;
            frame = ($urandom_range(0, 9) == 0) ? 8'($urandom_range(0, 10))
                                                : 8'($urandom_range(11, 255));
            st    = ($urandom_range(0, 7) == 0) ? wild_stamp() : near_stamp();
            send_item(op, pack_item(frame, st, 1'($urandom_range(0, 1))),
                      burst ? 0 : pick_gap());
        end
        @(negedge clk);
        s_tvalid <= 1'b0;

        while (sb.awaited.size() != 0) @(posedge clk);
        repeat (20) @(posedge clk);
        if (sb.errors == 0)
            $display("tb_top: clean");
        else
            $display("tb_top: errors");
        $finish;
    end

    // Watchdog.
    initial
    begin
        #6_000_000;
        $display("tb_top: errors");
        $finish;
    end

endmodule
